[design/double_integrator_controller_assert.svh]
// ----------------------------------------------------------------------------
// double integrator controller assertion macros
// concurrent checks used by the controller design file
// ----------------------------------------------------------------------------
`ifndef DOUBLE_INTEGRATOR_CONTROLLER_ASSERT_SVH
`define DOUBLE_INTEGRATOR_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define DIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dic_pkg.sv]
// ----------------------------------------------------------------------------
// dic_pkg
// types, constants and helpers of the double integrator controller
// ----------------------------------------------------------------------------
package dic_pkg;

    localparam int LIMB_W = 24;
    localparam int ACC_W  = 96;
    localparam int ST_W   = 48;
    localparam int FRAC_BITS = 24;

    localparam logic [10:0] DRIVE_MAX  = 11'd1000;
    localparam logic [31:0] K2_RESET   = 32'd3277;
    localparam logic [23:0] TS_RESET   = 24'd16777;
    localparam logic [7:0]  TICKS_MAX  = 8'd255;

    typedef enum logic [1:0] {
        REG_REFERENCE,
        REG_GAIN_K2,
        REG_GAIN_KP,
        REG_SAMPLE_PERIOD
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KE,
        ST_YP,
        ST_TC,
        ST_TA,
        ST_TB,
        ST_X1,
        ST_X2,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic       en;
        logic       clear;
        logic [1:0] limb;
    } t_mac_ctrl;

    // clamp a 52-bit signed sum to the 48-bit signed state range
    function automatic logic [ST_W-1:0] f_sat48(input logic [51:0] v);
        logic [ST_W-1:0] res;
        if ((v[51:47] == 5'b00000) || (v[51:47] == 5'b11111)) begin
            res = v[ST_W-1:0];
        end else if (v[51]) begin
            res = {1'b1, {(ST_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ST_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

[design/dic_mac.sv]
// ----------------------------------------------------------------------------
// dic_mac
// shared 24 x 24 unsigned multiplier with a limb-shifted accumulator
// ----------------------------------------------------------------------------
module dic_mac (
    input  logic                          i_clk,
    input  dic_pkg::t_mac_ctrl            i_ctrl,
    input  logic [dic_pkg::LIMB_W-1:0]    i_a,
    input  logic [dic_pkg::LIMB_W-1:0]    i_b,
    output logic [dic_pkg::ACC_W-1:0]     o_acc
);
    import dic_pkg::*;

    logic [2*LIMB_W-1:0] w_prod;
    logic [ACC_W-1:0]    w_term;
    logic [ACC_W-1:0]    w_base;
    logic [ACC_W-1:0]    r_acc;

    assign w_prod = i_a * i_b;
    assign w_base = i_ctrl.clear ? '0 : r_acc;

    always_comb begin
        unique case (i_ctrl.limb)
            2'd0:    w_term = {{(ACC_W-2*LIMB_W){1'b0}}, w_prod};
            2'd1:    w_term = {{(ACC_W-3*LIMB_W){1'b0}}, w_prod, {LIMB_W{1'b0}}};
            2'd2:    w_term = {w_prod, {(2*LIMB_W){1'b0}}};
            default: w_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_acc <= w_base + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

[design/double_integrator_controller.sv]
// ----------------------------------------------------------------------------
// double_integrator_controller
// double integrator control loop with anti-windup and shut-off latch
// ----------------------------------------------------------------------------
// A control step, from the sample transfer to the result being offered, makes
// eleven passes through the one 24 x 24 multiplier (k2*e, kp*e, Ts*k2*e, Ts*x2
// and Ts*Ts*k2*e, split into 24-bit limbs), then forms the state sums in ST_X1
// and ST_X2 and truncates and clamps in ST_FIN; the next sample can be taken
// once the sequencer is back in idle and no result is held stalled, so no new
// sample is taken while a step is in flight. While the output is latched off,
// or the reference is zero, the result is offered in the cycle after the
// transfer and the state is kept. Registers are written over the configuration
// port only while no step is in flight, and a pending write holds off the next
// sample; a reference write clears both integrators and the saturation count.
`include "double_integrator_controller_assert.svh"

module double_integrator_controller #(
    parameter int unsigned SAT_LIMIT = 200
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [9:0]         i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [10:0] o_drive,
    output logic               o_at_limit,
    output logic               o_shut_off,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import dic_pkg::*;

    t_state            r_state, n_state;
    logic [1:0]        r_limb, n_limb;
    t_mac_ctrl         w_mac_ctrl;
    logic [LIMB_W-1:0] w_mac_a, w_mac_b;
    logic [71:0]       w_b_full;
    logic [ACC_W-1:0]  w_acc;

    logic [9:0]        r_reference;
    logic [31:0]       r_k2, r_kp;
    logic [23:0]       r_ts;
    logic [ST_W-1:0]   r_outer, r_inner;
    logic [7:0]        r_sat_ticks;

    logic [9:0]        r_err_mag;
    logic              r_err_neg;
    logic [40:0]       r_ke_mag, r_yp_mag;
    logic              r_ke_neg, r_yp_neg;
    logic [64:0]       r_cf;
    logic [ST_W-1:0]   r_ta, r_x1, r_x2;
    logic [51:0]       r_sum;

    logic              r_out_valid;
    logic [10:0]       r_drive;
    logic              r_at_limit, r_shut_off;

    logic              w_accept, w_cfg_we, w_latched, w_bypass;
    logic [10:0]       w_err, w_err_abs;
    logic [31:0]       w_k2_mag, w_kp_mag;
    logic [ST_W-1:0]   w_inner_mag, w_tb;
    logic [48:0]       w_tc;
    logic [51:0]       w_ta_s, w_tb_s, w_tc_s, w_yp_s;
    logic [51:0]       w_x1_sum, w_x2_sum, w_sum, w_sum_abs;
    logic [27:0]       w_mag;
    logic              w_at_lim;
    logic [10:0]       w_mag11, w_drive;

    // handshakes
    assign o_stall     = (r_state != ST_IDLE) || (r_out_valid && i_stall) || i_cfg_valid;
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_latched   = (r_sat_ticks >= 8'(SAT_LIMIT));
    assign w_bypass    = w_latched || (r_reference == '0);

    // magnitudes and signs
    assign w_err       = {1'b0, r_reference} - {1'b0, i_sample};
    assign w_err_abs   = w_err[10] ? (~w_err + 11'd1) : w_err;
    assign w_k2_mag    = r_k2[31] ? (~r_k2 + 32'd1) : r_k2;
    assign w_kp_mag    = r_kp[31] ? (~r_kp + 32'd1) : r_kp;
    assign w_inner_mag = r_inner[ST_W-1] ? (~r_inner + 48'd1) : r_inner;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_limb  <= '0;
        end else begin
            r_state <= n_state;
            r_limb  <= n_limb;
        end
    end

    always_comb begin
        logic [1:0] v_last;
        t_state     v_next;
        logic       v_mul;
        n_state          = r_state;
        n_limb           = r_limb;
        v_last           = 2'd1;
        v_next           = r_state;
        v_mul            = 1'b0;
        w_mac_a          = r_ts;
        w_b_full         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && !w_bypass) begin
                    n_state = ST_KE;
                    n_limb  = '0;
                end
            end
            ST_KE: begin
                v_mul    = 1'b1;
                v_next   = ST_YP;
                w_mac_a  = {14'd0, r_err_mag};
                w_b_full = {40'd0, w_k2_mag};
            end
            ST_YP: begin
                v_mul    = 1'b1;
                v_next   = ST_TC;
                w_mac_a  = {14'd0, r_err_mag};
                w_b_full = {40'd0, w_kp_mag};
            end
            ST_TC: begin
                v_mul    = 1'b1;
                v_next   = ST_TA;
                w_b_full = {31'd0, r_ke_mag};
            end
            ST_TA: begin
                v_mul    = 1'b1;
                v_next   = ST_TB;
                w_b_full = {24'd0, w_inner_mag};
            end
            ST_TB: begin
                v_mul    = 1'b1;
                v_next   = ST_X1;
                v_last   = 2'd2;
                w_b_full = {7'd0, r_cf};
            end
            ST_X1:  n_state = ST_X2;
            ST_X2:  n_state = ST_FIN;
            ST_FIN: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (v_mul) begin
            if (r_limb == v_last) begin
                n_limb  = '0;
                n_state = v_next;
            end else begin
                n_limb = r_limb + 2'd1;
            end
        end
        w_mac_ctrl.en    = v_mul;
        w_mac_ctrl.clear = (r_limb == 2'd0);
        w_mac_ctrl.limb  = r_limb;
    end

    assign w_mac_b = w_b_full[LIMB_W*r_limb +: LIMB_W];

    dic_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_mac_ctrl),
        .i_a    (w_mac_a),
        .i_b    (w_mac_b),
        .o_acc  (w_acc)
    );

    // state sums
    assign w_tb     = w_acc[88:41];
    assign w_tc     = r_cf[64:16];
    assign w_ta_s   = r_inner[ST_W-1] ? (~{4'd0, r_ta} + 52'd1) : {4'd0, r_ta};
    assign w_tb_s   = r_ke_neg ? (~{4'd0, w_tb} + 52'd1) : {4'd0, w_tb};
    assign w_tc_s   = r_ke_neg ? (~{3'd0, w_tc} + 52'd1) : {3'd0, w_tc};
    assign w_yp_s   = r_yp_neg ? (~{3'd0, r_yp_mag, 8'd0} + 52'd1)
                               : {3'd0, r_yp_mag, 8'd0};
    assign w_x1_sum = {{4{r_outer[ST_W-1]}}, r_outer} + w_ta_s + w_tb_s;
    assign w_x2_sum = {{4{r_inner[ST_W-1]}}, r_inner} + w_tc_s;
    assign w_sum    = {{4{r_x1[ST_W-1]}}, r_x1} + w_yp_s;

    // truncation toward zero and clamp
    assign w_sum_abs = r_sum[51] ? (~r_sum + 52'd1) : r_sum;
    assign w_mag     = w_sum_abs[51:FRAC_BITS];
    assign w_at_lim  = (w_mag >= {17'd0, DRIVE_MAX});
    assign w_mag11   = w_at_lim ? DRIVE_MAX : w_mag[10:0];
    assign w_drive   = r_sum[51] ? (~w_mag11 + 11'd1) : w_mag11;

    // control state, registers and integrators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_reference <= '0;
            r_k2        <= K2_RESET;
            r_kp        <= '0;
            r_ts        <= TS_RESET;
            r_outer     <= '0;
            r_inner     <= '0;
            r_sat_ticks <= '0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept && w_bypass) begin
                r_out_valid <= 1'b1;
            end
            if (r_state == ST_FIN) begin
                r_out_valid <= 1'b1;
                if (w_at_lim) begin
                    if (r_sat_ticks != TICKS_MAX) begin
                        r_sat_ticks <= r_sat_ticks + 8'd1;
                    end
                    r_outer <= {{13{w_drive[10]}}, w_drive, {FRAC_BITS{1'b0}}};
                    r_inner <= '0;
                end else begin
                    r_sat_ticks <= '0;
                    r_outer     <= r_x1;
                    r_inner     <= r_x2;
                end
            end
            if (w_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_REFERENCE: begin
                        r_reference <= i_cfg_data[9:0];
                        r_outer     <= '0;
                        r_inner     <= '0;
                        r_sat_ticks <= '0;
                    end
                    REG_GAIN_K2:       r_k2 <= i_cfg_data;
                    REG_GAIN_KP:       r_kp <= i_cfg_data;
                    REG_SAMPLE_PERIOD: r_ts <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err_mag  <= w_err_abs[9:0];
            r_err_neg  <= w_err[10];
            r_drive    <= '0;
            r_at_limit <= 1'b0;
            r_shut_off <= w_latched;
        end
        unique case (r_state)
            ST_YP: begin
                if (r_limb == 2'd0) begin
                    r_ke_mag <= w_acc[40:0];
                    r_ke_neg <= r_k2[31] ^ r_err_neg;
                end
            end
            ST_TC: begin
                if (r_limb == 2'd0) begin
                    r_yp_mag <= w_acc[40:0];
                    r_yp_neg <= r_kp[31] ^ r_err_neg;
                end
            end
            ST_TA: begin
                if (r_limb == 2'd0) begin
                    r_cf <= w_acc[64:0];
                end
            end
            ST_TB: begin
                if (r_limb == 2'd0) begin
                    r_ta <= w_acc[71:24];
                end
            end
            ST_X1: r_x1 <= f_sat48(w_x1_sum);
            ST_X2: begin
                r_x2  <= f_sat48(w_x2_sum);
                r_sum <= w_sum;
            end
            ST_FIN: begin
                r_drive    <= w_drive;
                r_at_limit <= w_at_lim;
                r_shut_off <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_drive    = $signed(r_drive);
    assign o_at_limit = r_at_limit;
    assign o_shut_off = r_shut_off;

    `DIC_ASSERT_NOW(a_shut_zero, i_clk, i_rst_n, o_valid && o_shut_off, (o_drive == 11'sd0) && !o_at_limit, "shut-off result with nonzero drive")
    `DIC_ASSERT_NOW(a_limit_drive, i_clk, i_rst_n, o_valid && o_at_limit, (o_drive == 11'sd1000) || (o_drive == -11'sd1000), "limit flag without full drive")
    `DIC_ASSERT_NOW(a_fin_free, i_clk, i_rst_n, r_state == ST_FIN, !r_out_valid, "result register busy at step end")
    `DIC_ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, r_state == ST_FIN, o_valid && (r_state == ST_IDLE), "step end not followed by result")

endmodule

[tb/sv/double_integrator_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_integrator_controller_tb
// Checks the double integrator controller against its own bit-exact predictor
// of the integrator pair, the clamped drive and the shut-off latch. A short
// directed run covers zero reference, field extremes, integrator saturation
// and a zero sample period. A forced saturation run hits the latch. Random
// settings then follow, with samples mostly near the reference and random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module double_integrator_controller_tb;
    import dic_pkg::*;

    localparam int unsigned SAT_LIMIT     = 200;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          ITEM_TARGET   = 1500;
    localparam logic signed [63:0] STATE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] STATE_MIN = -64'sh0000_8000_0000_0000;
    localparam logic [63:0]        TERM_CAP  = 64'd1 << 52;

    typedef struct packed {
        logic signed [10:0] drive;
        logic               at_limit;
        logic               shut_off;
    } t_ctrl_out;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [9:0]         i_sample    = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic signed [10:0] o_drive;
    logic               o_at_limit;
    logic               o_shut_off;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data  = '0;

    double_integrator_controller #(
        .SAT_LIMIT(SAT_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_drive    (o_drive),
        .o_at_limit (o_at_limit),
        .o_shut_off (o_shut_off),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predicted controller registers and state
    logic [9:0]         target  = '0;
    logic signed [31:0] k2      = K2_RESET;
    logic signed [31:0] kp      = '0;
    logic [23:0]        ts      = TS_RESET;
    logic signed [47:0] x_outer = '0;
    logic signed [47:0] x_inner = '0;
    logic [7:0]         sat_run = '0;

    logic [9:0] sample_q[$];
    t_ctrl_out  drive_q[$];
    t_ctrl_out  due;

    bit sample_took = 1'b0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int gap_left    = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int errors      = 0;
    int n_queued    = 0;
    int n_samples   = 0;
    int n_checked   = 0;
    int n_writes    = 0;
    int n_settings  = 0;
    int n_at_limit  = 0;
    int n_shut_off  = 0;

    function automatic logic [63:0] scaled_mag(input logic [63:0] a, input logic [63:0] b,
                                               input int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, TERM_CAP}) ? TERM_CAP : p[63:0];
    endfunction

    function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [63:0] clamp_state(input logic signed [63:0] v);
        if (v > STATE_MAX) return STATE_MAX;
        if (v < STATE_MIN) return STATE_MIN;
        return v;
    endfunction

    function automatic void apply_register(input t_reg_idx idx, input logic [31:0] data);
        case (idx)
            REG_REFERENCE: begin
                target  = data[9:0];
                x_outer = '0;
                x_inner = '0;
                sat_run = '0;
            end
            REG_GAIN_K2:       k2 = data;
            REG_GAIN_KP:       kp = data;
            REG_SAMPLE_PERIOD: ts = data[23:0];
            default: ;
        endcase
    endfunction

    function automatic t_ctrl_out control_step(input logic [9:0] adc);
        t_ctrl_out          res;
        logic signed [63:0] err, ke, xo, xi, x1, x2, yp, total, drv;
        logic [63:0]        ke_mag, ts_w, ts_sq, mag;
        logic               ke_neg, hit;
        res = '0;
        if (sat_run >= SAT_LIMIT) begin
            res.shut_off = 1'b1;
            return res;
        end
        if (target == 10'd0) return res;
        err    = $signed({54'd0, target}) - $signed({54'd0, adc});
        ke     = err * k2;
        ke_neg = ke < 0;
        ke_mag = abs64(ke);
        ts_w   = {40'd0, ts};
        ts_sq  = ts_w * ts_w;
        xo     = x_outer;
        xi     = x_inner;
        x1 = clamp_state(xo + with_sign(scaled_mag(ts_w, abs64(xi), FRAC_BITS), xi < 0)
                            + with_sign(scaled_mag(ts_sq, ke_mag, 41), ke_neg));
        x2 = clamp_state(xi + with_sign(scaled_mag(ts_w, ke_mag, 16), ke_neg));
        yp    = err * kp;
        total = x1 + (yp <<< 8);
        mag   = abs64(total) >> FRAC_BITS;
        hit   = mag >= DRIVE_MAX;
        if (hit) mag = DRIVE_MAX;
        drv = with_sign(mag, total < 0);
        if (hit) begin
            if (sat_run != TICKS_MAX) sat_run = sat_run + 8'd1;
            x_outer = {drv[23:0], 24'd0};
            x_inner = '0;
        end else begin
            sat_run = '0;
            x_outer = x1[47:0];
            x_inner = x2[47:0];
        end
        res.drive    = drv[10:0];
        res.at_limit = hit;
        return res;
    endfunction

    function automatic int pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_gain(input logic [31:0] span);
        int unsigned r;
        logic [31:0] g;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            g = $urandom_range(0, span);
            if ($urandom_range(0, 1) == 1) g = -g;
        end else if (r < 8) begin
            case ($urandom_range(0, 4))
                0:       g = 32'h7FFF_FFFF;
                1:       g = 32'h8000_0000;
                2:       g = 32'h0000_0000;
                3:       g = 32'hFFFF_FFFF;
                default: g = 32'h0000_0001;
            endcase
        end else begin
            g = $urandom();
        end
        return g;
    endfunction

    function automatic logic [9:0] pick_adc();
        int unsigned r;
        int          v;
        r = $urandom_range(0, 19);
        if (r < 13) begin
            v = int'(target) + int'($urandom_range(0, 32)) - 16;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
        end else if (r < 18) begin
            v = $urandom_range(0, 1023);
        end else begin
            v = ($urandom_range(0, 1) == 1) ? 1023 : 0;
        end
        return v[9:0];
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) $display("ERROR: %s", msg);
    endtask

    // sample transfer and result check
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("double_integrator_controller: mismatch");
            $finish;
        end
        sample_took <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(t_reg_idx'(i_cfg_index), i_cfg_data);
                n_writes++;
            end
            if (i_valid && !o_stall) begin
                drive_q.push_back(control_step(i_sample));
                n_samples++;
            end
            if (o_valid && !i_stall) begin
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none pending", n_checked));
                end else begin
                    due = drive_q.pop_front();
                    if (o_drive !== due.drive)
                        report_mismatch($sformatf("result %0d drive %0d, want %0d",
                                                  n_checked, o_drive, due.drive));
                    if (o_at_limit !== due.at_limit)
                        report_mismatch($sformatf("result %0d at_limit %b, want %b",
                                                  n_checked, o_at_limit, due.at_limit));
                    if (o_shut_off !== due.shut_off)
                        report_mismatch($sformatf("result %0d shut_off %b, want %b",
                                                  n_checked, o_shut_off, due.shut_off));
                    if (due.at_limit) n_at_limit++;
                    if (due.shut_off) n_shut_off++;
                end
                n_checked++;
            end
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        if (sample_took) begin
            sample_q.delete(0);
            gap_left = tx_idle_on ? pick_pause() : 0;
        end
        if (i_valid && !sample_took) begin
            // hold the stalled transfer
        end else if (gap_left > 0 || sample_q.size() == 0) begin
            i_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end else begin
            i_valid  <= 1'b1;
            i_sample <= sample_q[0];
        end
    end

    // result stall
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left = pick_pause();
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic wait_idle();
        while (sample_q.size() != 0 || drive_q.size() != 0 || i_valid) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic close_writes();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic queue_adc(input logic [9:0] a);
        sample_q.push_back(a);
        n_queued++;
    endtask

    task automatic reprogram();
        int unsigned start;
        logic [31:0] hi;
        logic [31:0] data;
        logic [23:0] per;
        logic [9:0]  tgt;
        t_reg_idx    idx;
        start = $urandom_range(0, 3);
        for (int j = 0; j < 4; j++) begin
            idx = t_reg_idx'((start + j) % 4);
            hi  = $urandom();
            if ($urandom_range(0, 99) < ((idx == REG_REFERENCE) ? 85 : 70)) begin
                case (idx)
                    REG_REFERENCE: begin
                        case ($urandom_range(0, 19))
                            0:       tgt = 10'd0;
                            1:       tgt = 10'h3FF;
                            default: tgt = 10'($urandom_range(1, 1023));
                        endcase
                        data = {hi[31:10], tgt};
                    end
                    REG_GAIN_K2: data = pick_gain(32'h0010_0000);
                    REG_GAIN_KP: data = pick_gain(32'h0004_0000);
                    default: begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: per = 24'($urandom_range(1, 65535));
                            4:          per = 24'd0;
                            5:          per = ($urandom_range(0, 1) == 1) ? 24'hFF_FFFF : 24'd1;
                            default:    per = 24'($urandom_range(1, 24'hFF_FFFF));
                        endcase
                        data = {hi[31:24], per};
                    end
                endcase
                write_reg(idx, data);
            end
        end
        close_writes();
    endtask

    task automatic run_phase(input int n_items);
        int half;
        half       = ($urandom_range(0, 1) == 1) ? n_items / 2 : n_items;
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
        for (int i = 0; i < n_items; i++) begin
            // sender holds off until every result is back
            if (i == half) wait_idle();
            queue_adc(pick_adc());
        end
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // zero reference after reset
        queue_adc(10'd0);
        queue_adc(10'h3FF);
        wait_idle();

        write_reg(REG_REFERENCE, 32'h0000_0200);
        write_reg(REG_GAIN_KP, 32'h0001_0000);
        close_writes();
        queue_adc(10'd0);
        queue_adc(10'h3FF);
        queue_adc(10'd512);
        queue_adc(10'd511);
        queue_adc(10'd513);
        wait_idle();

        // both integrators pinned at full scale while kp cancels the drive
        write_reg(REG_GAIN_K2, 32'h7FFF_FFFF);
        write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_KP, 32'hDFF7_FE00);
        write_reg(REG_REFERENCE, 32'hFFFF_FFFF);
        close_writes();
        queue_adc(10'd0);
        queue_adc(10'd0);
        queue_adc(10'd0);
        wait_idle();

        write_reg(REG_GAIN_K2, 32'h8000_0000);
        write_reg(REG_GAIN_KP, 32'h8000_0000);
        close_writes();
        queue_adc(10'd0);
        queue_adc(10'h3FF);
        wait_idle();

        // zero sample period
        write_reg(REG_SAMPLE_PERIOD, 32'hAB00_0000);
        write_reg(REG_GAIN_KP, 32'h7FFF_FFFF);
        write_reg(REG_REFERENCE, 32'h0000_0001);
        close_writes();
        queue_adc(10'd1);
        queue_adc(10'd0);
        queue_adc(10'h3FF);
        wait_idle();

        // long saturation run into the shut-off latch
        write_reg(REG_GAIN_K2, 32'd3277);
        write_reg(REG_GAIN_KP, 32'h000A_0000);
        write_reg(REG_SAMPLE_PERIOD, 32'd16777);
        write_reg(REG_REFERENCE, $urandom_range(600, 1023));
        close_writes();
        for (int i = 0; i < 230; i++) queue_adc(10'($urandom_range(0, int'(target) - 300)));
        wait_idle();
        write_reg(REG_REFERENCE, $urandom_range(1, 1023));
        close_writes();

        while (n_queued < ITEM_TARGET) begin
            reprogram();
            run_phase($urandom_range(60, 200));
        end

        $display("%0d samples under %0d register settings (%0d writes), %0d results checked",
                 n_samples, n_settings, n_writes, n_checked);
        $display("%0d results at the drive limit, %0d with the output shut off",
                 n_at_limit, n_shut_off);
        if (errors == 0) begin
            $display("double_integrator_controller: match");
        end else begin
            $display("double_integrator_controller: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/dic_pkg.sv
design/dic_mac.sv
design/double_integrator_controller.sv
tb/sv/double_integrator_controller_tb.sv
